[design/cses_pkg.sv]
// Shared types, widths and constants of the calibrated strip energy sum block.
// Depends on nothing; the front, back, emitter and top level files import it.
`timescale 1ns / 1ps
`default_nettype none

package cses_pkg;

    // Field widths of the item, result and configuration channels.
    localparam int CHAN_W    = 7;
    localparam int COUNT_W   = 16;
    localparam int GAIN_W    = 20;
    localparam int OFFS_W    = 20;
    localparam int CFG_W     = 20;
    localparam int SUM_W     = 31;
    localparam int GIDX_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Number of distinct channel codes the channel field can carry.
    localparam int CHAN_CODES = 1 << CHAN_W;

    // Datapath widths: count*gain is Q.24, dropping 8 bits gives Q.16.
    localparam int PROD_W   = COUNT_W + GAIN_W;
    localparam int FRAC_CUT = 8;
    localparam int ESUM_W   = PROD_W - FRAC_CUT + 2;
    localparam int ENERGY_W = ESUM_W - 1;

    // Default sizing.
    localparam int DEF_NUM_CHANNELS     = 128;
    localparam int DEF_STRIPS_PER_GROUP = 16;

    // Queue depths between the parts.
    localparam int OPQ_DEPTH  = 4;
    localparam int RESQ_DEPTH = 2;

    // Register reset values: 0.5 MeV and 8 MeV in Q4.16.
    localparam logic [CFG_W-1:0] THRESHOLD_RESET   = CFG_W'(32768);
    localparam logic [CFG_W-1:0] WINDOW_HIGH_RESET = CFG_W'(524288);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = CFG_IDX_W'(1);

    // Command codes of an input item.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Kind of work handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SAMPLE,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [CHAN_W-1:0]         channel;
        logic [COUNT_W-1:0]        adc_count;
        logic [GAIN_W-1:0]         gain_word;
        logic signed [OFFS_W-1:0]  offset_word;
        logic                      event_end;
    } op_t;

    typedef struct packed {
        logic [GIDX_W-1:0] group_index;
        logic [SUM_W-1:0]  energy_sum;
        logic              in_window;
        logic              pair_in_window;
        logic              last_of_run;
    } result_t;

    // Window test: strictly above the threshold and strictly below the upper bound.
    function automatic logic in_win(input logic [SUM_W-1:0] sum,
                                    input logic [CFG_W-1:0] thr,
                                    input logic [CFG_W-1:0] hi);
        logic above_thr;
        logic below_hi;
        above_thr = sum > {{(SUM_W-CFG_W){1'b0}}, thr};
        below_hi  = sum < {{(SUM_W-CFG_W){1'b0}}, hi};
        return above_thr && below_hi;
    endfunction

endpackage

`default_nettype wire

[design/cses_queue.sv]
// Small first-in first-out queue of registers used between the parts of the block.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module cses_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[design/cses_front.sv]
// Front part: accepts input items, checks the channel range and classifies each item.
// Depends on cses_pkg; feeds the operation queue.
`timescale 1ns / 1ps
`default_nettype none

module cses_front
    import cses_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                      push,
    output logic                      full,
    input  logic                      command,
    input  logic [CHAN_W-1:0]         channel,
    input  logic [COUNT_W-1:0]        adc_count,
    input  logic [GAIN_W-1:0]         gain_word,
    input  logic signed [OFFS_W-1:0]  offset_word,
    input  logic                      event_end,
    input  logic                      q_full,
    output logic                      q_push,
    output op_t                       q_data
);

    logic     chan_ok;
    logic     keep;
    op_kind_t kind;

    assign chan_ok = int'(channel) < NUM_CHANNELS;

    // Classify: loads and samples of real channels go on; an out-of-range sample
    // survives only as an event end marker; anything else is dropped.
    always_comb
    begin
        kind = OP_LOAD;
        keep = 1'b0;
        unique case (command)
            CMD_LOAD:
            begin
                kind = OP_LOAD;
                keep = chan_ok;
            end
            CMD_SAMPLE:
            begin
                if (chan_ok)
                begin
                    kind = OP_SAMPLE;
                    keep = 1'b1;
                end
                else
                begin
                    kind = OP_END;
                    keep = event_end;
                end
            end
            default:
            begin
                kind = OP_LOAD;
                keep = 1'b0;
            end
        endcase
    end

    assign full   = q_full;
    assign q_push = push && !q_full && keep;

    always_comb
    begin
        q_data.kind        = kind;
        q_data.channel     = channel;
        q_data.adc_count   = adc_count;
        q_data.gain_word   = gain_word;
        q_data.offset_word = offset_word;
        q_data.event_end   = event_end;
    end

endmodule

`default_nettype wire

[design/cses_back.sv]
// Back part: calibration memory, multiply, threshold and per-group accumulation.
// Depends on cses_pkg; takes work from the operation queue and hands sums to the emitter.
`timescale 1ns / 1ps
`default_nettype none

module cses_back
    import cses_pkg::*;
#(
    parameter int NUM_CHANNELS     = DEF_NUM_CHANNELS,
    parameter int STRIPS_PER_GROUP = DEF_STRIPS_PER_GROUP
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_empty,
    output logic                                      q_pop,
    input  op_t                                       q_data,
    input  logic [CFG_W-1:0]                          thr,
    input  logic                                      emit_busy,
    output logic                                      capture,
    output logic [NUM_CHANNELS/STRIPS_PER_GROUP-1:0][SUM_W-1:0] sums
);

    localparam int NUM_GROUPS = NUM_CHANNELS / STRIPS_PER_GROUP;
    localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int AW         = $clog2(NUM_CHANNELS);
    localparam int CAL_W      = GAIN_W + OFFS_W;

    // Calibration memory: gain in the upper bits, offset in the lower bits.
    logic [CAL_W-1:0]  cal_mem [NUM_CHANNELS];
    logic [CAL_W-1:0]  cal_rd_reg;

    // Channel to group table.
    logic [GW-1:0]     grp_lut [CHAN_CODES];

    logic              adv;
    logic [AW-1:0]     mem_addr;

    // Stage 1: memory read done.
    logic              s1_valid_reg;
    logic              s1_sample_reg;
    logic              s1_end_reg;
    logic [GW-1:0]     s1_grp_reg;
    logic [COUNT_W-1:0] s1_count_reg;

    // Stage 2: product registered.
    logic              s2_valid_reg;
    logic              s2_sample_reg;
    logic              s2_end_reg;
    logic [GW-1:0]     s2_grp_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic signed [OFFS_W-1:0] s2_off_reg;

    // Stage 3: calibrated energy and threshold decision.
    logic              s3_valid_reg;
    logic              s3_above_reg;
    logic              s3_end_reg;
    logic [GW-1:0]     s3_grp_reg;
    logic [ENERGY_W-1:0] s3_energy_reg;

    logic signed [ESUM_W-1:0] energy_s;
    logic              above_next;
    logic [SUM_W-1:0]  acc_reg [NUM_GROUPS];
    logic [SUM_W-1:0]  acc_cur;
    logic [SUM_W:0]    acc_add;
    logic [SUM_W-1:0]  acc_sat;

    genvar c;
    for (c = 0; c < CHAN_CODES; c++)
    begin : g_lut
        assign grp_lut[c] = GW'(c / STRIPS_PER_GROUP);
    end

    // The whole pipeline holds while an event end waits for the emitter.
    assign adv      = !(s3_valid_reg && s3_end_reg && emit_busy);
    assign q_pop    = adv && !q_empty;
    assign mem_addr = AW'(q_data.channel);

    // Calibration memory write for loads, registered read for samples.
    always_ff @(posedge clk)
    begin
        if (q_pop && (q_data.kind == OP_LOAD))
        begin
            cal_mem[mem_addr] <= {q_data.gain_word, q_data.offset_word};
        end
        if (q_pop && (q_data.kind == OP_SAMPLE))
        begin
            cal_rd_reg <= cal_mem[mem_addr];
        end
    end

    // Stage valid and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_sample_reg <= 1'b0;
            s1_end_reg    <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_sample_reg <= 1'b0;
            s2_end_reg    <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_above_reg  <= 1'b0;
            s3_end_reg    <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop && (q_data.kind != OP_LOAD);
            s1_sample_reg <= q_data.kind == OP_SAMPLE;
            s1_end_reg    <= (q_data.kind == OP_END) ||
                             ((q_data.kind == OP_SAMPLE) && q_data.event_end);
            s2_valid_reg  <= s1_valid_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_end_reg    <= s1_end_reg;
            s3_valid_reg  <= s2_valid_reg;
            s3_above_reg  <= above_next;
            s3_end_reg    <= s2_end_reg;
        end
    end

    // Calibrated energy: product truncated to Q.16 plus the signed offset.
    assign energy_s = $signed({2'b00, s2_prod_reg[PROD_W-1:FRAC_CUT]}) +
                      $signed({{(ESUM_W-OFFS_W){s2_off_reg[OFFS_W-1]}}, s2_off_reg});
    assign above_next = s2_valid_reg && s2_sample_reg &&
                        (energy_s > $signed({{(ESUM_W-CFG_W){1'b0}}, thr}));

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_grp_reg    <= grp_lut[q_data.channel];
            s1_count_reg  <= q_data.adc_count;
            s2_grp_reg    <= s1_grp_reg;
            s2_prod_reg   <= PROD_W'(s1_count_reg * cal_rd_reg[CAL_W-1:OFFS_W]);
            s2_off_reg    <= $signed(cal_rd_reg[OFFS_W-1:0]);
            s3_grp_reg    <= s2_grp_reg;
            s3_energy_reg <= energy_s[ENERGY_W-1:0];
        end
    end

    // Saturating add into the selected group.
    assign acc_cur = acc_reg[s3_grp_reg];
    assign acc_add = {1'b0, acc_cur} + {{(SUM_W+1-ENERGY_W){1'b0}}, s3_energy_reg};
    assign acc_sat = acc_add[SUM_W] ? {SUM_W{1'b1}} : acc_add[SUM_W-1:0];

    assign capture = adv && s3_valid_reg && s3_end_reg;

    // Per-group lanes: sum after this cycle's add, cleared once captured.
    genvar g;
    for (g = 0; g < NUM_GROUPS; g++)
    begin : g_acc
        always_comb
        begin
            sums[g] = acc_reg[g];
            if (adv && s3_valid_reg && s3_above_reg && (s3_grp_reg == GW'(g)))
            begin
                sums[g] = acc_sat;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[g] <= '0;
            end
            else if (capture)
            begin
                acc_reg[g] <= '0;
            end
            else
            begin
                acc_reg[g] <= sums[g];
            end
        end
    end

endmodule

`default_nettype wire

[design/cses_emit.sv]
// Emitter: snapshots group sums at an event end; sends one result per cycle unless its queue is full.
// Depends on cses_pkg and cses_queue, which buffers the results.
`timescale 1ns / 1ps
`default_nettype none

module cses_emit
    import cses_pkg::*;
#(
    parameter int NUM_GROUPS = DEF_NUM_CHANNELS / DEF_STRIPS_PER_GROUP
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  capture,
    input  logic [NUM_GROUPS-1:0][SUM_W-1:0]      sums,
    output logic                                  busy,
    input  logic [CFG_W-1:0]                      thr,
    input  logic [CFG_W-1:0]                      win_high,
    input  logic                                  res_pop,
    output logic                                  res_empty,
    output result_t                               res_data
);

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int RW = $clog2(NUM_GROUPS + 1);

    // One spare slot at the end reads as zero when the last group shifts in.
    logic [SUM_W-1:0] snap_reg [NUM_GROUPS+1];
    logic [RW-1:0]    rem_reg;
    logic [GW-1:0]    idx_reg;
    logic             prev_win_reg;
    logic             res_full;
    logic             res_push;
    logic             win0;
    logic             win1;
    result_t          res_next;

    assign busy     = (rem_reg != '0);
    assign res_push = busy && !res_full;
    assign win0     = in_win(snap_reg[0], thr, win_high);
    assign win1     = in_win(snap_reg[1], thr, win_high);

    // Result fields of the group at the head of the snapshot.
    always_comb
    begin
        res_next.group_index    = GIDX_W'(idx_reg);
        res_next.energy_sum     = snap_reg[0];
        res_next.in_window      = win0;
        res_next.pair_in_window = win0 && (idx_reg[0] ? prev_win_reg
                                                      : ((rem_reg > RW'(1)) && win1));
        res_next.last_of_run    = (rem_reg == RW'(1));
    end

    // Sweep control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            idx_reg      <= '0;
            prev_win_reg <= 1'b0;
        end
        else if (capture)
        begin
            rem_reg <= RW'(NUM_GROUPS);
            idx_reg <= '0;
        end
        else if (res_push)
        begin
            rem_reg      <= rem_reg - 1'b1;
            idx_reg      <= idx_reg + 1'b1;
            prev_win_reg <= win0;
        end
    end

    // Snapshot shift line.
    always_ff @(posedge clk)
    begin
        snap_reg[NUM_GROUPS] <= '0;
        for (int i = 0; i < NUM_GROUPS; i++)
        begin
            if (capture)
            begin
                snap_reg[i] <= sums[i];
            end
            else if (res_push)
            begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    cses_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESQ_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_next),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (res_data),
        .empty (res_empty)
    );

endmodule

`default_nettype wire

[design/calibrated_strip_energy_sum.sv]
// Top level of the calibrated strip energy sum block: configuration registers and
// the front, operation queue, back and emitter parts. Depends on cses_pkg.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-------------------------------------------
//   input    | push / full          | command, channel, adc_count, gain_word,
//            |                      | offset_word, event_end
//   result   | empty / pop          | group_index, energy_sum, in_window,
//            |                      | pair_in_window, last_of_run
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is taken per cycle while full is low; a sample passes memory read,
// multiply, threshold and accumulate stages. The emitter sends one result per cycle
// while its result queue has room; if the previous event is still being sent, an
// event end holds the back pipeline until that sweep ends, the longer while pop is low;
// the operation queue takes up to OPQ_DEPTH items meanwhile and then raises full.
// Reset clears the accumulators and restores the registers; the calibration memory
// keeps no reset state.
`timescale 1ns / 1ps
`default_nettype none

module calibrated_strip_energy_sum
    import cses_pkg::*;
#(
    parameter int NUM_CHANNELS     = DEF_NUM_CHANNELS,
    parameter int STRIPS_PER_GROUP = DEF_STRIPS_PER_GROUP
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      command,
    input  logic [CHAN_W-1:0]         channel,
    input  logic [COUNT_W-1:0]        adc_count,
    input  logic [GAIN_W-1:0]         gain_word,
    input  logic signed [OFFS_W-1:0]  offset_word,
    input  logic                      event_end,
    output logic                      empty,
    input  logic                      pop,
    output logic [GIDX_W-1:0]         group_index,
    output logic [SUM_W-1:0]          energy_sum,
    output logic                      in_window,
    output logic                      pair_in_window,
    output logic                      last_of_run,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int NUM_GROUPS = NUM_CHANNELS / STRIPS_PER_GROUP;

    logic [CFG_W-1:0] thr_reg;
    logic [CFG_W-1:0] thr_next;
    logic [CFG_W-1:0] win_high_reg;
    logic [CFG_W-1:0] win_high_next;

    logic             q_full;
    logic             q_push;
    logic             q_empty;
    logic             q_pop;
    op_t              q_wdata;
    op_t              q_rdata;
    logic             capture;
    logic             emit_busy;
    logic [NUM_GROUPS-1:0][SUM_W-1:0] sums;
    result_t          res_data;

    // Configuration register decode.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next      = thr_reg;
        win_high_next = win_high_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:   thr_next      = cfg_data;
                REG_WINDOW_HIGH: win_high_next = cfg_data;
                default:
                begin
                    thr_next      = thr_reg;
                    win_high_next = win_high_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THRESHOLD_RESET;
            win_high_reg <= WINDOW_HIGH_RESET;
        end
        else
        begin
            thr_reg      <= thr_next;
            win_high_reg <= win_high_next;
        end
    end

    cses_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .push        (push),
        .full        (full),
        .command     (command),
        .channel     (channel),
        .adc_count   (adc_count),
        .gain_word   (gain_word),
        .offset_word (offset_word),
        .event_end   (event_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    cses_queue #(
        .WIDTH ($bits(op_t)),
        .DEPTH (OPQ_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    cses_back #(
        .NUM_CHANNELS     (NUM_CHANNELS),
        .STRIPS_PER_GROUP (STRIPS_PER_GROUP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_rdata),
        .thr       (thr_reg),
        .emit_busy (emit_busy),
        .capture   (capture),
        .sums      (sums)
    );

    cses_emit #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (capture),
        .sums      (sums),
        .busy      (emit_busy),
        .thr       (thr_reg),
        .win_high  (win_high_reg),
        .res_pop   (pop),
        .res_empty (empty),
        .res_data  (res_data)
    );

    assign group_index    = res_data.group_index;
    assign energy_sum     = res_data.energy_sum;
    assign in_window      = res_data.in_window;
    assign pair_in_window = res_data.pair_in_window;
    assign last_of_run    = res_data.last_of_run;

`ifndef SYNTH
    // A snapshot is never taken while the previous event is still being sent.
    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> !emit_busy)
        else $error("group sums captured while emitter busy");

    // A capture starts a sweep in the next cycle.
    a_capture_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> emit_busy)
        else $error("capture did not start the result sweep");

    // The final result of an event belongs to the highest group.
    a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_run) |-> (group_index == GIDX_W'(NUM_GROUPS - 1)))
        else $error("last result carries the wrong group");

    // A pair flag needs the group itself in the window.
    a_pair_window: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pair_in_window) |-> in_window)
        else $error("pair flag set without window flag");
`endif

endmodule

`default_nettype wire
